@@ hdl/lcd_decimal_digit_writer_assert.svh @@
// Assertion macros for the decimal digit writer, clocked on clk with reset rst_n.
`ifndef LCD_DECIMAL_DIGIT_WRITER_ASSERT_SVH
`define LCD_DECIMAL_DIGIT_WRITER_ASSERT_SVH

// Property checked only outside reset.
`define LDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define LDW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ldw_pkg.sv @@
// Types, constants and segment code tables of the decimal digit writer.
`timescale 1ns / 1ps

package ldw_pkg;

  localparam int unsigned NUM_PLACES = 6;
  localparam int unsigned NUM_ROWS   = 4;
  localparam int unsigned NUM_COLS   = 3;
  localparam int unsigned MEM_DEPTH  = NUM_ROWS * NUM_COLS;
  localparam int unsigned MEM_AW     = $clog2(MEM_DEPTH);
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned CONV_BITS  = 32;

  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;

  localparam logic [4:0] LAST_STEP_NUMBER = 5'(NUM_PLACES * NUM_ROWS - 1);
  localparam logic [4:0] LAST_STEP_CHAR   = 5'(NUM_ROWS - 1);

  localparam logic OP_NUMBER = 1'b0;
  localparam logic OP_CHAR   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] value;
    logic [7:0]  character;
    logic [2:0]  position;
  } ldw_in_t;

  typedef struct packed {
    logic [4:0] reg_address;
    logic [7:0] reg_data;
    logic       last;
  } ldw_out_t;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_RMW,
    ST_DRAIN
  } ldw_state_t;

  // Segment code of one decimal digit; every segment of an eight is lit.
  function automatic logic [15:0] seg_code(input logic [3:0] d);
    case (d)
      4'd0: return 16'h1551;
      4'd1: return 16'h0110;
      4'd2: return 16'h11E1;
      4'd3: return 16'h11B1;
      4'd4: return 16'h05B0;
      4'd5: return 16'h14B1;
      4'd6: return 16'h14F1;
      4'd7: return 16'h1110;
      4'd8: return 16'h15F1;
      4'd9: return 16'h15B0;
      default: return 16'h0000;
    endcase
  endfunction

  // Segment code of an ASCII character; anything but a digit is blank.
  function automatic logic [15:0] char_code(input logic [7:0] ch);
    logic [7:0] ofs;
    ofs = ch - CHAR_ZERO;
    if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
      return 16'h0000;
    end
    return seg_code(ofs[3:0]);
  endfunction

  // Nibble of a segment code for one row, most significant nibble first.
  function automatic logic [3:0] code_nibble(input logic [15:0] code, input logic [1:0] row);
    case (row)
      2'd0: return code[15:12];
      2'd1: return code[11:8];
      2'd2: return code[7:4];
      2'd3: return code[3:0];
      default: return 4'h0;
    endcase
  endfunction

endpackage

@@ hdl/ldw_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module ldw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/ldw_bcd.sv @@
// Shift-and-add-three converter from a 32-bit binary number to ten BCD digits.
`timescale 1ns / 1ps

module ldw_bcd (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   value,
  output logic          done,
  output ldw_pkg::bcd_t digits
);
  import ldw_pkg::*;

  localparam int unsigned CNT_W = $clog2(CONV_BITS);

  logic [31:0]      bin_r, bin_nxt;
  bcd_t             bcd_r, bcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  bcd_t             adj;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt = value;
      bcd_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = bcd_t'({adj, bin_r[31]});
      bin_nxt = {bin_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CONV_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done   = done_r;
  assign digits = bcd_r;

endmodule

@@ hdl/lcd_decimal_digit_writer.sv @@
// Top level of the decimal digit writer for a segment display memory.
`timescale 1ns / 1ps
//
//  Channel   Ports                      Beat taken when
//  --------  -------------------------  ---------------------------------
//  input     start, busy, in_item       start high and busy low at clk
//  result    out_strobe, out_item       out_strobe high (one cycle each)
//
// A character beat keeps busy high through a read-modify-write step per
// row of its place, using the display RAM read port, then a drain state.
// A number beat keeps busy high through the bit-serial BCD conversion, a
// hand-over, a read-modify-write step per row of every place and a drain.
// Result beats follow the RAM writes in the next cycle, one per cycle.
// A character beat at a place above five is taken at once and gives no
// result. The synchronous reset empties the display by clearing one valid
// bit per entry; the receiver cannot stall, so the block never waits on it.

`include "lcd_decimal_digit_writer_assert.svh"

module lcd_decimal_digit_writer #(
  parameter int unsigned ROW_STRIDE = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ldw_pkg::ldw_in_t in_item,
  output logic             out_strobe,
  output ldw_pkg::ldw_out_t out_item
);
  import ldw_pkg::*;

  // Sequencer state and the captured item.
  ldw_state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       op_r;
  logic [7:0] char_r;
  logic [2:0] pos_r;

  logic       accept;
  logic       bcd_start;
  logic       bcd_done;
  bcd_t       bcd_digits;
  logic       issue;
  logic [4:0] last_step;
  logic       step_is_last;

  // Decode of the current step into a display entry and a nibble.
  logic [2:0]            place_i;
  logic [1:0]            row;
  logic [2:0]            place;
  logic [1:0]            col;
  logic                  shown;
  logic [15:0]           code;
  logic [3:0]            nib;
  logic [MEM_AW-1:0]     rd_idx;
  logic [4:0]            rd_addr;
  logic [BCD_DIGITS-1:0] digit_nz;
  logic [BCD_DIGITS-1:0] nz_from;

  // Read stage: registered alongside the RAM read.
  logic              s1_valid_r;
  logic [MEM_AW-1:0] s1_idx_r;
  logic [4:0]        s1_addr_r;
  logic [3:0]        s1_nib_r;
  logic              s1_odd_r;
  logic              s1_last_r;
  logic              rd_valid_r;

  // Write stage.
  logic [7:0]           rd_data;
  logic [7:0]           old_byte;
  logic [7:0]           new_byte;
  logic [MEM_DEPTH-1:0] valid_r;

  logic     out_strobe_r;
  ldw_out_t out_item_r;

  ldw_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bcd_start),
    .value  (in_item.value),
    .done   (bcd_done),
    .digits (bcd_digits)
  );

  ldw_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_idx_r),
    .wdata (new_byte),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.op == OP_NUMBER) begin
            state_nxt = ST_CONVERT;
          end else if (in_item.position <= 3'(NUM_PLACES - 1)) begin
            state_nxt = ST_RMW;
          end
        end
      end
      ST_CONVERT: begin
        if (bcd_done) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        if (step_is_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy         = (state_r != ST_IDLE);
    accept       = start && !busy;
    bcd_start    = accept && (in_item.op == OP_NUMBER);
    issue        = (state_r == ST_RMW);
    last_step    = (op_r == OP_NUMBER) ? LAST_STEP_NUMBER : LAST_STEP_CHAR;
    step_is_last = (step_r == last_step);
    step_nxt     = step_r;
    if (accept) begin
      step_nxt = '0;
    end else if (issue) begin
      step_nxt = step_r + 5'd1;
    end
  end

  // A place of a number is lit when it or any higher BCD digit is non-zero;
  // the units place is always lit so that zero shows as a single nought.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      digit_nz[i] = (bcd_digits[i] != 4'd0);
    end
    nz_from[BCD_DIGITS-1] = digit_nz[BCD_DIGITS-1];
    for (int i = BCD_DIGITS - 2; i >= 0; i--) begin
      nz_from[i] = nz_from[i+1] | digit_nz[i];
    end
  end

  // Steps run in groups of four rows per place; numbers fill places five
  // down to nought, units first.
  always_comb begin
    place_i = step_r[4:2];
    row     = step_r[1:0];
    shown   = 1'b0;
    if (op_r == OP_NUMBER) begin
      place = 3'(NUM_PLACES - 1) - place_i;
      shown = (place_i == 3'd0) || nz_from[{1'b0, place_i}];
      code  = shown ? seg_code(bcd_digits[{1'b0, place_i}]) : 16'h0000;
    end else begin
      place = pos_r;
      code  = char_code(char_r);
    end
    col     = place[2:1];
    nib     = code_nibble(code, row);
    rd_idx  = MEM_AW'(row) * MEM_AW'(NUM_COLS) + MEM_AW'(col);
    rd_addr = 5'(col) + 5'(row) * 5'(ROW_STRIDE);
  end

  // Merge the new nibble into the half of the byte that the place owns. An
  // entry never written since reset reads as zero.
  always_comb begin
    old_byte = rd_valid_r ? rd_data : 8'h00;
    new_byte = s1_odd_r ? {s1_nib_r, old_byte[3:0]} : {old_byte[7:4], s1_nib_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      s1_valid_r   <= 1'b0;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      s1_valid_r   <= issue;
      out_strobe_r <= s1_valid_r;
      if (s1_valid_r) begin
        valid_r[s1_idx_r] <= 1'b1;
      end
    end
    if (accept) begin
      op_r   <= in_item.op;
      char_r <= in_item.character;
      pos_r  <= in_item.position;
    end
    s1_idx_r   <= rd_idx;
    s1_addr_r  <= rd_addr;
    s1_nib_r   <= nib;
    s1_odd_r   <= place[0];
    s1_last_r  <= step_is_last;
    rd_valid_r <= valid_r[rd_idx];
    out_item_r <= '{reg_address: s1_addr_r, reg_data: new_byte, last: s1_last_r};
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // The write of one step never targets the entry read in the same cycle.
  `LDW_ASSERT(a_no_rmw_overlap, !(issue && s1_valid_r && rd_idx == s1_idx_r), "same-entry read during write")
  // The final beat of an item is never followed by another beat at once.
  `LDW_ASSERT(a_last_gap, (out_strobe && out_item.last) |=> !out_strobe, "beat right after final beat")
  // Busy drops exactly as the final beat of the item appears.
  `LDW_ASSERT(a_busy_ends_on_last, ($fell(busy) && $past(rst_n)) |-> (out_strobe && out_item.last), "busy fell without final beat")
  // No write is left in flight when a new item can be taken.
  `LDW_ASSERT_ALWAYS(a_idle_drained, (rst_n && !busy) |-> !s1_valid_r, "write pending while idle")

endmodule
